// File: design/memory_stack_vm_execute_unit_macros.svh
// Assertion macros used by the execute stage of the memory stack execute unit.
`ifndef MEMORY_STACK_VM_EXECUTE_UNIT_MACROS_SVH
`define MEMORY_STACK_VM_EXECUTE_UNIT_MACROS_SVH

// Clocked property on i_clk, switched off while i_rst_n is low.
`define MSVEU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// A condition that must never hold at a clock edge outside reset.
`define MSVEU_ASSERT_NEVER(label, cond, msg) \
    `MSVEU_ASSERT(label, !(cond), msg)

`endif

// File: design/msveu_pkg.sv
// Shared types and constants of the memory stack execute unit.
package msveu_pkg;

    localparam int DATA_W       = 32;
    localparam int PLEN_W       = 16;
    localparam int OP_W         = 4;
    localparam int IN_TDATA_W   = 64;
    localparam int OUT_TDATA_W  = 72;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Register index as decoded from the word address bit of paddr.
    localparam logic REG_IDX_PROGRAM_LENGTH = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_PRINT = 4'd0,
        OP_LOAD  = 4'd1,
        OP_LOADI = 4'd2,
        OP_ADD   = 4'd3,
        OP_SUB   = 4'd4,
        OP_MUL   = 4'd5,
        OP_CMP   = 4'd6,
        OP_JUMP  = 4'd7,
        OP_JZE   = 4'd8,
        OP_JNE   = 4'd9,
        OP_PUSH  = 4'd10,
        OP_PUSHI = 4'd11,
        OP_POP   = 4'd12,
        OP_CALL  = 4'd13,
        OP_RET   = 4'd14,
        OP_HALT  = 4'd15
    } t_opcode;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_ADDR      = 2'd1,
        ERR_UNDERFLOW = 2'd2,
        ERR_OVERFLOW  = 2'd3
    } t_error;

    // Classified instruction as it waits in the queue.
    typedef struct packed {
        t_opcode           op;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        logic              addr_fault;
    } t_instr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic queue_full;
        logic clearing;
    } t_front_ctl;

    typedef struct packed {
        logic [DATA_W-1:0] next_pc;
        logic              print_valid;
        logic [DATA_W-1:0] print_value;
        t_error            error_code;
        logic              stopped;
    } t_result;

endpackage

// File: design/msveu_front.sv
// Front end: takes instruction words from the stream and classifies their addresses.
module msveu_front #(
    parameter int MEM_DEPTH = 256
) (
    input  logic                                i_s_axis_tvalid,
    // tuser: req_type[3:0]
    input  logic [msveu_pkg::OP_W-1:0]          i_s_axis_tuser,
    // tdata: operand_a[31:0], operand_b[63:32]
    input  logic [msveu_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                                o_s_axis_tready,
    input  msveu_pkg::t_front_ctl               i_ctl,
    output logic                                o_push,
    output msveu_pkg::t_instr                   o_instr
);
    import msveu_pkg::*;

    t_opcode           op;
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    logic              a_ok;
    logic              b_ok;
    logic              fault;

    assign op     = t_opcode'(i_s_axis_tuser);
    assign opnd_a = i_s_axis_tdata[DATA_W-1:0];
    assign opnd_b = i_s_axis_tdata[2*DATA_W-1:DATA_W];
    assign a_ok   = opnd_a < DATA_W'(MEM_DEPTH);
    assign b_ok   = opnd_b < DATA_W'(MEM_DEPTH);

    // Which operands name memory words decides the address check.
    always_comb begin
        unique case (op)
            OP_PRINT, OP_LOADI, OP_PUSH, OP_POP: begin
                fault = !a_ok;
            end
            OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_CMP: begin
                fault = !a_ok || !b_ok;
            end
            OP_JUMP, OP_JZE, OP_JNE, OP_PUSHI, OP_CALL, OP_RET, OP_HALT: begin
                fault = 1'b0;
            end
        endcase
    end

    assign o_s_axis_tready    = !i_ctl.queue_full && !i_ctl.clearing;
    assign o_push             = i_s_axis_tvalid && o_s_axis_tready;
    assign o_instr.op         = op;
    assign o_instr.a          = opnd_a;
    assign o_instr.b          = opnd_b;
    assign o_instr.addr_fault = fault;

endmodule

// File: design/msveu_queue.sv
// Short instruction queue between the front end and the execute stage.
module msveu_queue (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  msveu_pkg::t_instr        i_data,
    input  logic                     i_pop,
    output msveu_pkg::t_instr        o_head,
    output msveu_pkg::t_queue_status o_status
);
    import msveu_pkg::*;

    t_instr            r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_status.full  = r_count == QCNT_W'(QUEUE_DEPTH);
    assign o_status.empty = r_count == '0;
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// File: design/msveu_back.sv
// Execute stage: data memory, stack, flag and program counter, with the result register.
`include "memory_stack_vm_execute_unit_macros.svh"

module msveu_back #(
    parameter int MEM_DEPTH   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic [msveu_pkg::PLEN_W-1:0]     i_program_length,
    input  msveu_pkg::t_queue_status         i_queue,
    input  msveu_pkg::t_instr                i_head,
    output logic                             o_pop,
    output logic                             o_clearing,
    output logic                             o_result_valid,
    output msveu_pkg::t_result               o_result,
    input  logic                             i_result_ready
);
    import msveu_pkg::*;

    localparam int AW  = $clog2(MEM_DEPTH);
    localparam int SPW = $clog2(STACK_DEPTH + 1);
    localparam int SIW = $clog2(STACK_DEPTH);

    typedef enum logic {
        S_FETCH,
        S_EXEC
    } t_state;

    t_state            r_state;
    logic [DATA_W-1:0] r_mem [MEM_DEPTH];
    logic [DATA_W-1:0] r_stk [STACK_DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;
    logic [DATA_W-1:0] r_stk_rd;
    t_instr            r_item;
    logic [SPW-1:0]    r_sp;
    logic              r_zf;
    logic [DATA_W-1:0] r_pc;
    logic              r_running;
    logic              r_clr_busy;
    logic [AW-1:0]     r_clr_addr;
    logic              r_out_valid;
    t_result           r_out;

    logic [SPW-1:0]    sp_m1;
    logic [DATA_W-1:0] pc1;
    logic              halted_now;
    logic              stk_full;
    logic              stk_empty;
    logic              commit;
    logic              out_free;
    t_error            ex_err;
    logic              ex_pvalid;
    logic [DATA_W-1:0] ex_pval;
    logic [DATA_W-1:0] ex_next;
    logic              ex_halt;
    logic              ex_mem_we;
    logic [DATA_W-1:0] ex_mem_wd;
    logic              ex_stk_we;
    logic [DATA_W-1:0] ex_stk_wd;
    logic              ex_sp_inc;
    logic              ex_sp_dec;
    logic              ex_zf_we;
    logic              ex_stopped;
    t_result           ex_result;

    assign sp_m1      = r_sp - 1'b1;
    assign pc1        = r_pc + 1'b1;
    assign stk_full   = r_sp == SPW'(STACK_DEPTH);
    assign stk_empty  = r_sp == '0;
    assign halted_now = !r_running || (r_pc >= {{(DATA_W-PLEN_W){1'b0}}, i_program_length});
    assign out_free   = !r_out_valid || i_result_ready;
    assign commit     = (r_state == S_EXEC) && out_free;
    assign o_pop      = (r_state == S_FETCH) && !r_clr_busy && !i_queue.empty;
    assign o_clearing = r_clr_busy;

    always_comb begin
        ex_err    = ERR_NONE;
        ex_pvalid = 1'b0;
        ex_pval   = '0;
        ex_next   = pc1;
        ex_halt   = 1'b0;
        ex_mem_we = 1'b0;
        ex_mem_wd = '0;
        ex_stk_we = 1'b0;
        ex_stk_wd = '0;
        ex_sp_inc = 1'b0;
        ex_sp_dec = 1'b0;
        ex_zf_we  = 1'b0;
        if (halted_now) begin
            ex_next = r_pc;
        end else begin
            unique case (r_item.op)
                OP_PRINT: begin
                    if (r_item.addr_fault) begin
                        ex_err = ERR_ADDR;
                    end else begin
                        ex_pvalid = 1'b1;
                        ex_pval   = r_rd_a;
                    end
                end
                OP_LOAD, OP_LOADI, OP_ADD, OP_SUB, OP_MUL: begin
                    if (r_item.addr_fault) begin
                        ex_err = ERR_ADDR;
                    end else begin
                        ex_mem_we = 1'b1;
                    end
                    unique case (r_item.op)
                        OP_LOAD:  ex_mem_wd = r_rd_b;
                        OP_LOADI: ex_mem_wd = r_item.b;
                        OP_ADD:   ex_mem_wd = r_rd_a + r_rd_b;
                        OP_SUB:   ex_mem_wd = r_rd_a - r_rd_b;
                        OP_MUL:   ex_mem_wd = r_rd_a * r_rd_b;
                        default:  ex_mem_wd = '0;
                    endcase
                end
                OP_CMP: begin
                    if (r_item.addr_fault) begin
                        ex_err = ERR_ADDR;
                    end else begin
                        ex_zf_we = 1'b1;
                    end
                end
                OP_JUMP: begin
                    ex_next = r_item.a;
                end
                OP_JZE: begin
                    if (r_zf) begin
                        ex_next = r_item.a;
                    end
                end
                OP_JNE: begin
                    if (!r_zf) begin
                        ex_next = r_item.a;
                    end
                end
                OP_PUSH: begin
                    if (r_item.addr_fault) begin
                        ex_err = ERR_ADDR;
                    end else if (stk_full) begin
                        ex_err = ERR_OVERFLOW;
                    end else begin
                        ex_stk_we = 1'b1;
                        ex_stk_wd = r_rd_a;
                        ex_sp_inc = 1'b1;
                    end
                end
                OP_PUSHI: begin
                    if (stk_full) begin
                        ex_err = ERR_OVERFLOW;
                    end else begin
                        ex_stk_we = 1'b1;
                        ex_stk_wd = r_item.a;
                        ex_sp_inc = 1'b1;
                    end
                end
                OP_POP: begin
                    if (stk_empty) begin
                        ex_err = ERR_UNDERFLOW;
                    end else if (r_item.addr_fault) begin
                        ex_err = ERR_ADDR;
                    end else begin
                        ex_mem_we = 1'b1;
                        ex_mem_wd = r_stk_rd;
                        ex_sp_dec = 1'b1;
                    end
                end
                OP_CALL: begin
                    if (stk_full) begin
                        ex_err = ERR_OVERFLOW;
                    end else begin
                        ex_stk_we = 1'b1;
                        ex_stk_wd = pc1;
                        ex_sp_inc = 1'b1;
                        ex_next   = r_item.a;
                    end
                end
                OP_RET: begin
                    if (stk_empty) begin
                        ex_err = ERR_UNDERFLOW;
                    end else begin
                        ex_next   = r_stk_rd;
                        ex_sp_dec = 1'b1;
                    end
                end
                OP_HALT: begin
                    ex_halt = 1'b1;
                end
            endcase
        end
        ex_stopped = halted_now || ex_halt || (ex_err != ERR_NONE) ||
                     (ex_next >= {{(DATA_W-PLEN_W){1'b0}}, i_program_length});
    end

    assign ex_result.next_pc     = ex_next;
    assign ex_result.print_valid = ex_pvalid;
    assign ex_result.print_value = ex_pval;
    assign ex_result.error_code  = ex_err;
    assign ex_result.stopped     = ex_stopped;

    // Data memory: one write port shared by the clearing sweep, two registered reads.
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (commit && ex_mem_we) begin
            r_mem[r_item.a[AW-1:0]] <= ex_mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd_a <= r_mem[i_head.a[AW-1:0]];
            r_rd_b <= r_mem[i_head.b[AW-1:0]];
            r_item <= i_head;
        end
    end

    // Stack store: written at the stack pointer, read just below it.
    always_ff @(posedge i_clk) begin
        if (commit && ex_stk_we) begin
            r_stk[r_sp[SIW-1:0]] <= ex_stk_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_stk_rd <= r_stk[sp_m1[SIW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FETCH;
            r_sp        <= '0;
            r_zf        <= 1'b0;
            r_pc        <= '0;
            r_running   <= 1'b1;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == AW'(MEM_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            unique case (r_state)
                S_FETCH: begin
                    if (o_pop) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (commit) begin
                        r_state   <= S_FETCH;
                        r_pc      <= ex_next;
                        r_running <= !ex_stopped;
                        if (ex_zf_we) begin
                            r_zf <= r_rd_a == r_rd_b;
                        end
                        if (ex_sp_inc) begin
                            r_sp <= r_sp + 1'b1;
                        end else if (ex_sp_dec) begin
                            r_sp <= sp_m1;
                        end
                    end
                end
            endcase
            if (commit) begin
                r_out_valid <= 1'b1;
                r_out       <= ex_result;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    `MSVEU_ASSERT(a_sp_bound, r_sp <= SPW'(STACK_DEPTH), "stack pointer beyond stack depth")
    `MSVEU_ASSERT_NEVER(a_exec_during_clear, r_clr_busy && (o_pop || r_state == S_EXEC),
        "instruction taken during memory clear")
    `MSVEU_ASSERT(a_stay_stopped, !r_running |=> !r_running, "machine restarted without reset")
    `MSVEU_ASSERT(a_err_keeps_sp, (commit && ex_err != ERR_NONE) |=> $stable(r_sp),
        "failing instruction moved the stack pointer")

endmodule

// File: design/memory_stack_vm_execute_unit.sv
// The execute stage takes one instruction at a time: a fetch state reads its operands from
// the synchronous data memory, an execute state writes back once the result register is free.
// Reset: synchronous, active low; afterwards the data memory is cleared word by word,
// during which no instruction word is accepted (configuration writes are taken).
// Reset leaves pc at zero, stack empty, zero flag clear, machine running, program length zero.
module memory_stack_vm_execute_unit #(
    parameter int MEM_DEPTH   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Instruction stream in.
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tuser: req_type[3:0]
    input  logic [msveu_pkg::OP_W-1:0]          i_s_axis_tuser,
    // tdata: operand_a[31:0], operand_b[63:32]
    input  logic [msveu_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // Result stream out.
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: next_pc[31:0], print_valid[32], print_value[64:33], error_code[66:65],
    // stopped[67], zero[71:68]
    output logic [msveu_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    // Configuration port.
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [msveu_pkg::PADDR_W-1:0]       paddr,
    input  logic [msveu_pkg::PDATA_W-1:0]       pwdata,
    output logic [msveu_pkg::PDATA_W-1:0]       prdata,
    output logic                                pready
);
    import msveu_pkg::*;

    logic [PLEN_W-1:0] r_prog_len;
    logic              cfg_wr;
    t_front_ctl        front_ctl;
    t_queue_status     q_status;
    t_instr            push_instr;
    t_instr            head_instr;
    logic              push;
    logic              pop;
    logic              clearing;
    t_result           result;

    // The register file holds only the program length, at byte address zero.
    // Writes whose word address bit is set fall outside the list and are dropped.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prog_len <= '0;
        end else if (cfg_wr && (paddr[2] == REG_IDX_PROGRAM_LENGTH)) begin
            r_prog_len <= pwdata[PLEN_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_IDX_PROGRAM_LENGTH) begin
            prdata = {{(PDATA_W-PLEN_W){1'b0}}, r_prog_len};
        end else begin
            prdata = '0;
        end
    end

    // The front end stops taking words while the queue is full or the memory is
    // still being cleared; the execute stage drains the queue at its own pace.
    assign front_ctl.queue_full = q_status.full;
    assign front_ctl.clearing   = clearing;

    msveu_front #(
        .MEM_DEPTH (MEM_DEPTH)
    ) u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_s_axis_tready (o_s_axis_tready),
        .i_ctl           (front_ctl),
        .o_push          (push),
        .o_instr         (push_instr)
    );

    msveu_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_data   (push_instr),
        .i_pop    (pop),
        .o_head   (head_instr),
        .o_status (q_status)
    );

    // The execute stage reads both operand words and the stack top together as it pops an
    // instruction, then computes, writes back and loads the result register once the output is free.
    msveu_back #(
        .MEM_DEPTH   (MEM_DEPTH),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_program_length (r_prog_len),
        .i_queue          (q_status),
        .i_head           (head_instr),
        .o_pop            (pop),
        .o_clearing       (clearing),
        .o_result_valid   (o_m_axis_tvalid),
        .o_result         (result),
        .i_result_ready   (i_m_axis_tready)
    );

    assign o_m_axis_tdata = {4'b0000, result.stopped, result.error_code, result.print_value,
                             result.print_valid, result.next_pc};

endmodule

// File: sim/memory_stack_vm_execute_unit_checker.sv
// Watches the instruction, result and register channels and checks every result word.
module memory_stack_vm_execute_unit_checker #(
    parameter int MEM_DEPTH   = 256,
    parameter int STACK_DEPTH = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [msveu_pkg::OP_W-1:0]        i_s_tuser,
    input  logic [msveu_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [msveu_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [msveu_pkg::PADDR_W-1:0]     i_paddr,
    input  logic [msveu_pkg::PDATA_W-1:0]     i_pwdata,
    input  logic                              i_pready,
    output int                                o_fail_count,
    output int                                o_pending,
    output logic [msveu_pkg::DATA_W-1:0]      o_pc,
    output int                                o_stack_depth,
    output logic [msveu_pkg::DATA_W-1:0]      o_stack_top,
    output logic                              o_zero_flag
);
    timeunit 1ns;
    timeprecision 1ps;

    import msveu_pkg::*;

    // Machine state as the instructions accepted so far leave it.
    logic [DATA_W-1:0] data_words [MEM_DEPTH];
    logic [DATA_W-1:0] stack_words [STACK_DEPTH];
    int                sp;
    logic              zf;
    logic [DATA_W-1:0] pc;
    logic              running;
    logic [PLEN_W-1:0] prog_len;

    t_result instr_outcomes [$];

    assign o_pc          = pc;
    assign o_stack_depth = sp;
    assign o_stack_top   = (sp > 0) ? stack_words[sp-1] : '0;
    assign o_zero_flag   = zf;

    function automatic t_result execute_instr(input t_opcode op, input logic [DATA_W-1:0] a,
                                              input logic [DATA_W-1:0] b);
        t_result           res;
        logic [DATA_W-1:0] next;
        logic              a_ok;
        logic              b_ok;
        logic              full;
        logic              empty;
        logic              halt;
        res   = '0;
        next  = pc + 1;
        a_ok  = a < MEM_DEPTH;
        b_ok  = b < MEM_DEPTH;
        full  = sp >= STACK_DEPTH;
        empty = sp == 0;
        halt  = 1'b0;
        // A stopped machine, or a pc outside the program, leaves everything but running alone.
        if (!running || pc >= 32'(prog_len)) begin
            running     = 1'b0;
            res.next_pc = pc;
            res.stopped = 1'b1;
            return res;
        end
        case (op)
            OP_PRINT: begin
                if (!a_ok) res.error_code = ERR_ADDR;
                else begin
                    res.print_valid = 1'b1;
                    res.print_value = data_words[a];
                end
            end
            OP_LOAD: begin
                if (!a_ok || !b_ok) res.error_code = ERR_ADDR;
                else data_words[a] = data_words[b];
            end
            OP_LOADI: begin
                if (!a_ok) res.error_code = ERR_ADDR;
                else data_words[a] = b;
            end
            OP_ADD: begin
                if (!a_ok || !b_ok) res.error_code = ERR_ADDR;
                else data_words[a] = data_words[a] + data_words[b];
            end
            OP_SUB: begin
                if (!a_ok || !b_ok) res.error_code = ERR_ADDR;
                else data_words[a] = data_words[a] - data_words[b];
            end
            OP_MUL: begin
                if (!a_ok || !b_ok) res.error_code = ERR_ADDR;
                else data_words[a] = data_words[a] * data_words[b];
            end
            OP_CMP: begin
                if (!a_ok || !b_ok) res.error_code = ERR_ADDR;
                else zf = data_words[a] == data_words[b];
            end
            OP_JUMP: next = a;
            OP_JZE: if (zf) next = a;
            OP_JNE: if (!zf) next = a;
            OP_PUSH: begin
                if (!a_ok) res.error_code = ERR_ADDR;
                else if (full) res.error_code = ERR_OVERFLOW;
                else begin
                    stack_words[sp] = data_words[a];
                    sp++;
                end
            end
            OP_PUSHI: begin
                if (full) res.error_code = ERR_OVERFLOW;
                else begin
                    stack_words[sp] = a;
                    sp++;
                end
            end
            OP_POP: begin
                if (empty) res.error_code = ERR_UNDERFLOW;
                else if (!a_ok) res.error_code = ERR_ADDR;
                else begin
                    sp--;
                    data_words[a] = stack_words[sp];
                end
            end
            OP_CALL: begin
                if (full) res.error_code = ERR_OVERFLOW;
                else begin
                    stack_words[sp] = next;
                    sp++;
                    next = a;
                end
            end
            OP_RET: begin
                if (empty) res.error_code = ERR_UNDERFLOW;
                else begin
                    sp--;
                    next = stack_words[sp];
                end
            end
            default: halt = 1'b1;
        endcase
        pc = next;
        if (halt || res.error_code != ERR_NONE || next >= 32'(prog_len)) running = 1'b0;
        res.next_pc = next;
        res.stopped = !running;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_result           want;
        t_result           fresh;
        logic [DATA_W-1:0] got_pc;
        logic              got_pvalid;
        logic [DATA_W-1:0] got_pvalue;
        logic [1:0]        got_err;
        logic              got_stopped;
        if (!i_rst_n) begin
            for (int i = 0; i < MEM_DEPTH; i++) data_words[i] = '0;
            for (int i = 0; i < STACK_DEPTH; i++) stack_words[i] = '0;
            sp       = 0;
            zf       = 1'b0;
            pc       = '0;
            running  = 1'b1;
            prog_len = '0;
            instr_outcomes.delete();
            o_pending    = 0;
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready &&
                i_paddr[2] == REG_IDX_PROGRAM_LENGTH) begin
                prog_len = i_pwdata[PLEN_W-1:0];
            end
            // Results are retired before new instructions are queued at the same edge.
            if (i_m_tvalid && i_m_tready) begin
                got_pc      = i_m_tdata[31:0];
                got_pvalid  = i_m_tdata[32];
                got_pvalue  = i_m_tdata[64:33];
                got_err     = i_m_tdata[66:65];
                got_stopped = i_m_tdata[67];
                if (instr_outcomes.size() == 0) begin
                    $error("result word with no instruction waiting: tdata %h", i_m_tdata);
                    o_fail_count++;
                end else begin
                    want = instr_outcomes.pop_front();
                    if (got_pc != want.next_pc) begin
                        $error("next_pc: expected %h, actual %h", want.next_pc, got_pc);
                        o_fail_count++;
                    end
                    if (got_pvalid != want.print_valid) begin
                        $error("print_valid: expected %b, actual %b", want.print_valid,
                               got_pvalid);
                        o_fail_count++;
                    end
                    if (got_pvalue != want.print_value) begin
                        $error("print_value: expected %h, actual %h", want.print_value,
                               got_pvalue);
                        o_fail_count++;
                    end
                    if (got_err != want.error_code) begin
                        $error("error_code: expected %0d, actual %0d", want.error_code, got_err);
                        o_fail_count++;
                    end
                    if (got_stopped != want.stopped) begin
                        $error("stopped: expected %b, actual %b", want.stopped, got_stopped);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                fresh = execute_instr(t_opcode'(i_s_tuser), i_s_tdata[31:0], i_s_tdata[63:32]);
                instr_outcomes.insert(instr_outcomes.size(), fresh);
            end
            o_pending = instr_outcomes.size();
        end
    end

endmodule

// File: sim/tb.sv
// Top of the execute unit testbench: clock, reset, instruction stimulus and the verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import msveu_pkg::*;

    localparam int MEM_WORDS    = 256;
    localparam int STACK_WORDS  = 64;
    localparam int NUM_PHASES   = 4;
    // The last words of the final phase go out with no idling on either side.
    localparam int QUIET_ITEMS  = 120;
    // Words sent after the machine has stopped; each still owes a result.
    localparam int STOPPED_ITEMS = 8;
    // Cycles left after the final result so that a stray extra word would still be seen.
    localparam int TAIL_CYCLES  = 20;
    localparam int TIMEOUT_NS   = 5_000_000;

    localparam logic [PADDR_W-1:0] PROGRAM_LENGTH_ADDR = {REG_IDX_PROGRAM_LENGTH, 2'b00};

    typedef enum int {
        BIAS_NONE,
        BIAS_PUSH,
        BIAS_POP
    } t_stack_bias;

    // Ways in which the run brings the machine to a stop.
    typedef enum int {
        END_HALT,
        END_BAD_ADDR,
        END_UNDERFLOW,
        END_OVERFLOW,
        END_PC_OUT,
        END_EMPTY_PROGRAM
    } t_end_kind;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // Instruction stream toward the block.
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [OP_W-1:0]        s_user = '0;
    logic [IN_TDATA_W-1:0]  s_data = '0;
    // Result stream from the block.
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_data;
    // Register port.
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    // State published by the checker, used to keep generated programs inside the rules.
    int                fail_count;
    int                pending_count;
    logic [DATA_W-1:0] model_pc;
    int                model_stack_depth;
    logic [DATA_W-1:0] model_stack_top;
    logic              model_zero_flag;

    logic [PLEN_W-1:0] cur_plen = '0;
    t_stack_bias       stk_bias = BIAS_NONE;
    logic              no_idle = 1'b0;
    int                instr_count = 0;
    int                settings_used = 0;
    int                peak_depth = 0;
    t_end_kind         end_kind = END_HALT;

    always #5 clk = ~clk;

    memory_stack_vm_execute_unit #(
        .MEM_DEPTH   (MEM_WORDS),
        .STACK_DEPTH (STACK_WORDS)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tuser  (s_user),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    memory_stack_vm_execute_unit_checker #(
        .MEM_DEPTH   (MEM_WORDS),
        .STACK_DEPTH (STACK_WORDS)
    ) exec_check (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_s_tvalid    (s_valid),
        .i_s_tready    (s_ready),
        .i_s_tuser     (s_user),
        .i_s_tdata     (s_data),
        .i_m_tvalid    (m_valid),
        .i_m_tready    (m_ready),
        .i_m_tdata     (m_data),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_pc          (model_pc),
        .o_stack_depth (model_stack_depth),
        .o_stack_top   (model_stack_top),
        .o_zero_flag   (model_zero_flag)
    );

    // Operand values that lean on the word extremes.
    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // A valid data memory address, with the first and last word favored.
    function automatic logic [DATA_W-1:0] rand_addr();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return MEM_WORDS - 1;
            default: return $urandom_range(MEM_WORDS - 1, 0);
        endcase
    endfunction

    // The receiver stalls in random bursts; the final part of the run never stalls.
    initial begin
        forever begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(negedge clk) begin
        if (model_stack_depth > peak_depth) peak_depth = model_stack_depth;
    end

    // Called at a falling edge; returns at the falling edge after the word was taken.
    // tvalid stays high on return, so back-to-back words keep it raised.
    task automatic send_instr(input t_opcode op, input logic [DATA_W-1:0] a,
                              input logic [DATA_W-1:0] b);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        s_valid <= 1'b1;
        s_user  <= op;
        s_data  <= {b, a};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        @(negedge clk);
        instr_count++;
    endtask

    // Stop sending and let every outstanding result come back.
    task automatic wait_all_retired();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge clk);
    endtask

    // Setup cycle, then access cycle; the write lands at the edge with pready high.
    task automatic write_program_length(input logic [PLEN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PROGRAM_LENGTH_ADDR;
        pwdata  <= 32'(value);
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cur_plen = value;
        settings_used++;
    endtask

    // Sends a word, first jumping back to the start if the pc sits on the last instruction.
    task automatic send_in_program(input t_opcode op, input logic [DATA_W-1:0] a,
                                   input logic [DATA_W-1:0] b);
        if (model_pc >= 32'(cur_plen) - 1) send_instr(OP_JUMP, '0, rand_word());
        send_instr(op, a, b);
    endtask

    // Draws an instruction that keeps the machine running: valid addresses, no stack
    // underflow or overflow, and control transfers that stay inside the program.
    task automatic pick_instr(output t_opcode op, output logic [DATA_W-1:0] a,
                              output logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] target;
        op     = t_opcode'($urandom_range(OP_RET, OP_PRINT));
        a      = rand_word();
        b      = rand_word();
        target = $urandom_range(32'(cur_plen) - 1, 0);
        if (stk_bias == BIAS_PUSH && op inside {OP_POP, OP_RET} && $urandom_range(0, 1) == 1)
            op = OP_PUSHI;
        if (stk_bias == BIAS_POP && op inside {OP_PUSH, OP_PUSHI, OP_CALL} &&
            $urandom_range(0, 1) == 1)
            op = OP_POP;
        if (op inside {OP_PUSH, OP_PUSHI, OP_CALL} && model_stack_depth >= STACK_WORDS)
            op = OP_POP;
        // A return address may be a pushed data word or one past the program end.
        if (op == OP_RET && (model_stack_depth == 0 || model_stack_top >= 32'(cur_plen)))
            op = OP_POP;
        if (op == OP_POP && model_stack_depth == 0) op = OP_PUSHI;
        // On the last instruction only a taken transfer keeps the pc inside the program.
        if (model_pc >= 32'(cur_plen) - 1 &&
            !(op inside {OP_JUMP, OP_CALL, OP_RET} || (op == OP_JZE && model_zero_flag) ||
              (op == OP_JNE && !model_zero_flag)))
            op = OP_JUMP;
        case (op)
            OP_PRINT, OP_PUSH, OP_POP, OP_LOADI: a = rand_addr();
            OP_LOAD, OP_ADD, OP_SUB, OP_MUL, OP_CMP: begin
                a = rand_addr();
                b = rand_addr();
            end
            OP_JUMP, OP_CALL: a = target;
            // A branch that is not taken ignores its target, so that stays raw noise.
            OP_JZE: if (model_zero_flag) a = target;
            OP_JNE: if (!model_zero_flag) a = target;
            default: ;
        endcase
    endtask

    initial begin
        t_opcode           op;
        logic [DATA_W-1:0] opa;
        logic [DATA_W-1:0] opb;
        logic [PLEN_W-1:0] phase_plen [NUM_PHASES];
        int                phase_items [NUM_PHASES];
        t_stack_bias       phase_bias [NUM_PHASES];

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // The register resets to zero, which would stop the machine on its first word.
        write_program_length(16'hFFFF);

        // Directed program: word extremes, wrapping arithmetic, every operation but halt,
        // taken and untaken branches, the last valid pc and a call and return pair.
        send_instr(OP_LOADI, 32'd0, 32'h7FFF_FFFF);
        send_instr(OP_LOADI, 32'd255, 32'h8000_0000);
        send_instr(OP_LOADI, 32'd1, 32'd1);
        send_instr(OP_ADD, 32'd0, 32'd1);
        send_instr(OP_SUB, 32'd255, 32'd1);
        send_instr(OP_PRINT, 32'd0, rand_word());
        send_instr(OP_PRINT, 32'd255, rand_word());
        send_instr(OP_LOADI, 32'd2, 32'hFFFF_FFFF);
        send_instr(OP_MUL, 32'd2, 32'd2);
        send_instr(OP_LOAD, 32'd3, 32'd2);
        send_instr(OP_CMP, 32'd2, 32'd3);
        send_instr(OP_JZE, 32'd100, rand_word());
        send_instr(OP_JNE, 32'hFFFF_FFFF, rand_word());
        send_instr(OP_CMP, 32'd0, 32'd1);
        send_instr(OP_JNE, 32'd5, rand_word());
        send_instr(OP_JZE, 32'hFFFF_FFFF, rand_word());
        send_instr(OP_JUMP, 32'd65533, rand_word());
        send_instr(OP_PUSH, 32'd0, rand_word());
        send_instr(OP_JUMP, 32'd3, rand_word());
        send_instr(OP_PUSHI, 32'hFFFF_FFFF, rand_word());
        send_instr(OP_CALL, 32'd200, rand_word());
        send_instr(OP_RET, rand_word(), rand_word());
        send_instr(OP_POP, 32'd4, rand_word());
        send_instr(OP_POP, 32'd254, rand_word());
        send_instr(OP_PRINT, 32'd4, rand_word());

        // Random phases: a one-instruction program, short programs that fill the stack,
        // medium ones that drain it, and finally the full length.
        phase_plen[0]  = 16'd1;
        phase_items[0] = 30;
        phase_bias[0]  = BIAS_NONE;
        phase_plen[1]  = 16'($urandom_range(16, 2));
        phase_items[1] = 200;
        phase_bias[1]  = BIAS_PUSH;
        phase_plen[2]  = 16'($urandom_range(1000, 17));
        phase_items[2] = 250;
        phase_bias[2]  = BIAS_POP;
        phase_plen[3]  = 16'hFFFF;
        phase_items[3] = 370;
        phase_bias[3]  = BIAS_NONE;

        for (int p = 0; p < NUM_PHASES; p++) begin
            // The length changes only with nothing in flight, and never below the pc.
            wait_all_retired();
            if (model_pc >= 32'(phase_plen[p])) begin
                send_instr(OP_JUMP, '0, rand_word());
                wait_all_retired();
            end
            write_program_length(phase_plen[p]);
            stk_bias = phase_bias[p];
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == NUM_PHASES - 1 && n >= phase_items[p] - QUIET_ITEMS) no_idle = 1'b1;
                pick_instr(op, opa, opb);
                send_instr(op, opa, opb);
            end
        end

        // Only reset restarts the machine, so the run ends on one randomly chosen stop.
        end_kind = t_end_kind'($urandom_range(END_EMPTY_PROGRAM, END_HALT));
        case (end_kind)
            END_HALT: send_in_program(OP_HALT, rand_word(), rand_word());
            END_BAD_ADDR: begin
                // Pop checks for underflow first, so make sure something is on the stack.
                if (model_stack_depth == 0) send_in_program(OP_PUSHI, rand_word(), rand_word());
                case ($urandom_range(0, 8))
                    0: op = OP_PRINT;
                    1: op = OP_LOAD;
                    2: op = OP_LOADI;
                    3: op = OP_ADD;
                    4: op = OP_SUB;
                    5: op = OP_MUL;
                    6: op = OP_CMP;
                    7: op = OP_PUSH;
                    default: op = OP_POP;
                endcase
                opa = rand_addr();
                opb = rand_addr();
                if (op inside {OP_PRINT, OP_LOADI, OP_PUSH, OP_POP} || $urandom_range(0, 1) == 1)
                    opa = $urandom_range(32'hFFFF_FFFF, MEM_WORDS);
                else
                    opb = $urandom_range(32'hFFFF_FFFF, MEM_WORDS);
                if (op == OP_LOADI) opb = rand_word();
                send_in_program(op, opa, opb);
            end
            END_UNDERFLOW: begin
                while (model_stack_depth > 0) send_in_program(OP_POP, rand_addr(), rand_word());
                send_in_program(($urandom_range(0, 1) == 1) ? OP_POP : OP_RET, rand_addr(),
                                rand_word());
            end
            END_OVERFLOW: begin
                while (model_stack_depth < STACK_WORDS)
                    send_in_program(OP_PUSHI, rand_word(), rand_word());
                case ($urandom_range(0, 2))
                    0: op = OP_PUSH;
                    1: op = OP_PUSHI;
                    default: op = OP_CALL;
                endcase
                send_in_program(op, rand_addr(), rand_word());
            end
            END_PC_OUT: begin
                if ($urandom_range(0, 1) == 1) begin
                    send_instr(OP_JUMP, $urandom_range(32'hFFFF_FFFF, 32'(cur_plen)), rand_word());
                end else begin
                    // Fall off the end: a plain instruction at the last valid pc.
                    send_instr(OP_JUMP, 32'(cur_plen) - 1, rand_word());
                    send_instr(OP_LOADI, rand_addr(), rand_word());
                end
            end
            default: begin
                wait_all_retired();
                write_program_length('0);
            end
        endcase

        // Whatever comes now must be ignored by the stopped machine.
        for (int n = 0; n < STOPPED_ITEMS; n++)
            send_instr(t_opcode'($urandom_range(OP_HALT, OP_PRINT)), rand_word(), rand_word());

        wait_all_retired();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d instruction words over %0d program length settings;",
                 instr_count, settings_used);
        $display("stack peaked at %0d of %0d; stopped by %s, then fed %0d more words.",
                 peak_depth, STACK_WORDS, end_kind.name(), STOPPED_ITEMS);
        if (fail_count == 0 && pending_count == 0) begin
            $display("memory_stack_vm_execute_unit verification clean");
        end else begin
            $display("memory_stack_vm_execute_unit verification failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("memory_stack_vm_execute_unit verification failed");
        $finish;
    end

endmodule

// File: sim.f
+incdir+design
design/msveu_pkg.sv
design/msveu_front.sv
design/msveu_queue.sv
design/msveu_back.sv
design/memory_stack_vm_execute_unit.sv
sim/memory_stack_vm_execute_unit_checker.sv
sim/tb.sv
